/* hdl/cbs_pkg.sv */
package cbs_pkg;

   localparam int COORD_BITS = 16;
   localparam int STEP_BITS  = 10;
   localparam int FRAC_BITS  = 16;

   localparam logic [STEP_BITS-1:0] SEG_RESET = STEP_BITS'(100);

   localparam int IN_BITS  = 8 * COORD_BITS + STEP_BITS;
   localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_BITS = 2 * COORD_BITS;
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;

   localparam int T_W     = FRAC_BITS + 1;
   localparam int P2_W    = 2 * FRAC_BITS + 1;
   localparam int W_SHIFT = 3 * FRAC_BITS;
   localparam int W_W     = W_SHIFT + 1;
   localparam int LIMB    = W_SHIFT / 2;
   localparam int HI_W    = W_W - LIMB;
   localparam int PH_W    = HI_W + COORD_BITS;
   localparam int PL_W    = LIMB + COORD_BITS;
   localparam int HS_W    = PH_W + 2;
   localparam int LS_W    = PL_W + 2;

   localparam logic [T_W-1:0]  T_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [HS_W-1:0] HI_ROUND = HS_W'(1) << (W_SHIFT - 1 - LIMB);

   localparam int S_TU       = DIV_STAGES + 1;
   localparam int S_MUL      = DIV_STAGES + 2;
   localparam int S_WGT      = DIV_STAGES + 3;
   localparam int S_PP       = DIV_STAGES + 4;
   localparam int S_SUM      = DIV_STAGES + 5;
   localparam int S_OUT      = DIV_STAGES + 6;
   localparam int NUM_STAGES = DIV_STAGES + 7;
   localparam int CNT_W      = $clog2(NUM_STAGES + 2);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef coord_type [3:0] quad_type;

   typedef struct packed {
      quad_type y;
      quad_type x;
   } pts_type;

endpackage

/* hdl/cubic_bezier_sampler_unit.sv */
// Cubic Bezier sampler. Each item on req carries the four control points of a
// segment and a step index j; the block returns the curve point at
// t = floor(j * 65536 / segment_count) as a Q1.16 fraction, with j clamped to
// the segment count (so j at or above the count gives the end point) and a
// count of zero taken as one. The weighted sum is exact and rounded to
// nearest, ties up. Coordinates are unsigned Q12.4. The block is a pipeline of
// 11 register stages: one input stage, 4 stages of a radix-2 long divider for
// t (4 quotient bits each), a stage for 1-t, then stages for the second and
// third powers, the per-point partial products, the sums and the output
// register. It takes one item per clock while rsp is not stalled; a stall
// holds the stages that are full and empty stages keep filling. The user must
// write segment_count through csr while no item is in flight; the block does
// not enforce this. A new count applies to the items accepted after it.
module cubic_bezier_sampler_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, step_index
   input  logic [cbs_pkg::IN_W-1:0]    req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // curve_x, curve_y
   output logic [cbs_pkg::OUT_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   // segment_count
   input  logic [cbs_pkg::STEP_BITS-1:0] csr_data
);
   import cbs_pkg::*;

   logic [STEP_BITS-1:0] seg_ff;
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] en;

   pts_type pts_ff [0:S_WGT];
   logic [STEP_BITS-1:0] div_seg_ff [0:DIV_STAGES-1];
   logic [STEP_BITS-1:0] div_rem_ff [0:DIV_STAGES-1];
   logic [T_W-1:0]       div_q_ff   [0:DIV_STAGES];
   logic [STEP_BITS-1:0] div_rem_in [1:DIV_STAGES];
   logic [T_W-1:0]       div_q_in   [1:DIV_STAGES];

   logic [T_W-1:0]  t_ff, u_ff, t6_ff, u6_ff;
   logic [P2_W-1:0] u2_ff, ut_ff, t2_ff;
   logic [W_W-1:0]  w_ff [0:3];
   logic [PH_W-1:0] pp_hi_ff [0:1][0:3];
   logic [PL_W-1:0] pp_lo_ff [0:1][0:3];
   logic [HS_W-1:0] hs_ff [0:1];
   logic [LS_W-1:0] ls_ff [0:1];
   coord_type       res_ff [0:1];

   // input stage signals
   pts_type              pts_in;
   logic [STEP_BITS-1:0] seg_eff, step_raw, step_cl;
   logic                 step_hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= SEG_RESET;
      end else if (csr_valid) begin
         seg_ff <= csr_data;
      end
   end

   // per-stage advance, an empty stage always loads
   always_comb begin
      en[NUM_STAGES-1] = ~v_ff[NUM_STAGES-1] | rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[S_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 0: unpack, clamp, first quotient bit
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pts_in.x[k] = req_tdata[(2*k)*COORD_BITS +: COORD_BITS];
         pts_in.y[k] = req_tdata[(2*k+1)*COORD_BITS +: COORD_BITS];
      end
      step_raw = req_tdata[8*COORD_BITS +: STEP_BITS];
      seg_eff  = (seg_ff == '0) ? STEP_BITS'(1) : seg_ff;
      step_cl  = (step_raw > seg_eff) ? seg_eff : step_raw;
      step_hit = (step_cl == seg_eff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pts_ff[0]     <= pts_in;
         div_seg_ff[0] <= seg_eff;
         div_rem_ff[0] <= step_hit ? '0 : step_cl;
         div_q_ff[0]   <= {{FRAC_BITS{1'b0}}, step_hit};
      end
   end

   // divider stages, DIV_STEP quotient bits each
   always_comb begin
      logic [STEP_BITS:0]   r2;
      logic [STEP_BITS-1:0] r;
      logic [T_W-1:0]       q;
      for (int d = 1; d <= DIV_STAGES; d++) begin
         r = div_rem_ff[d-1];
         q = div_q_ff[d-1];
         for (int i = 0; i < DIV_STEP; i++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, div_seg_ff[d-1]}) begin
               r2 = r2 - {1'b0, div_seg_ff[d-1]};
               q  = {q[T_W-2:0], 1'b1};
            end else begin
               q  = {q[T_W-2:0], 1'b0};
            end
            r = r2[STEP_BITS-1:0];
         end
         div_rem_in[d] = r;
         div_q_in[d]   = q;
      end
   end

   for (genvar gd = 1; gd <= DIV_STAGES; gd++) begin : g_div
      always_ff @(posedge clock) begin
         if (en[gd]) begin
            pts_ff[gd]   <= pts_ff[gd-1];
            div_q_ff[gd] <= div_q_in[gd];
         end
      end
      if (gd < DIV_STAGES) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[gd]) begin
               div_seg_ff[gd] <= div_seg_ff[gd-1];
               div_rem_ff[gd] <= div_rem_in[gd];
            end
         end
      end
   end

   // t and 1-t
   always_ff @(posedge clock) begin
      if (en[S_TU]) begin
         pts_ff[S_TU] <= pts_ff[S_TU-1];
         t_ff         <= div_q_ff[DIV_STAGES];
         u_ff         <= T_ONE - div_q_ff[DIV_STAGES];
      end
   end

   // second powers
   logic [P2_W-1:0] u2_in, ut_in, t2_in;
   assign u2_in = P2_W'(u_ff) * P2_W'(u_ff);
   assign ut_in = P2_W'(u_ff) * P2_W'(t_ff);
   assign t2_in = P2_W'(t_ff) * P2_W'(t_ff);

   always_ff @(posedge clock) begin
      if (en[S_MUL]) begin
         pts_ff[S_MUL] <= pts_ff[S_MUL-1];
         u2_ff         <= u2_in;
         ut_ff         <= ut_in;
         t2_ff         <= t2_in;
         u6_ff         <= u_ff;
         t6_ff         <= t_ff;
      end
   end

   // bernstein weights
   logic [P2_W+T_W-1:0] m0, m1, m2, m3;
   logic [P2_W+T_W+1:0] m1x3, m2x3;
   assign m0   = (P2_W+T_W)'(u2_ff) * (P2_W+T_W)'(u6_ff);
   assign m1   = (P2_W+T_W)'(ut_ff) * (P2_W+T_W)'(u6_ff);
   assign m2   = (P2_W+T_W)'(ut_ff) * (P2_W+T_W)'(t6_ff);
   assign m3   = (P2_W+T_W)'(t2_ff) * (P2_W+T_W)'(t6_ff);
   assign m1x3 = {2'b00, m1} + {1'b0, m1, 1'b0};
   assign m2x3 = {2'b00, m2} + {1'b0, m2, 1'b0};

   always_ff @(posedge clock) begin
      if (en[S_WGT]) begin
         pts_ff[S_WGT] <= pts_ff[S_WGT-1];
         w_ff[0]       <= m0[W_W-1:0];
         w_ff[1]       <= m1x3[W_W-1:0];
         w_ff[2]       <= m2x3[W_W-1:0];
         w_ff[3]       <= m3[W_W-1:0];
      end
   end

   // partial products, weight split in high and low limbs
   logic [PH_W-1:0] pp_hi_in [0:1][0:3];
   logic [PL_W-1:0] pp_lo_in [0:1][0:3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pp_hi_in[0][k] = PH_W'(w_ff[k][W_W-1:LIMB]) * PH_W'(pts_ff[S_WGT].x[k]);
         pp_lo_in[0][k] = PL_W'(w_ff[k][LIMB-1:0]) * PL_W'(pts_ff[S_WGT].x[k]);
         pp_hi_in[1][k] = PH_W'(w_ff[k][W_W-1:LIMB]) * PH_W'(pts_ff[S_WGT].y[k]);
         pp_lo_in[1][k] = PL_W'(w_ff[k][LIMB-1:0]) * PL_W'(pts_ff[S_WGT].y[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_PP]) begin
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
      end
   end

   // limb sums, rounding bit folded into the high limb
   logic [HS_W-1:0] hs_in [0:1];
   logic [LS_W-1:0] ls_in [0:1];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         hs_in[a] = HI_ROUND
                  + HS_W'(pp_hi_ff[a][0]) + HS_W'(pp_hi_ff[a][1])
                  + HS_W'(pp_hi_ff[a][2]) + HS_W'(pp_hi_ff[a][3]);
         ls_in[a] = LS_W'(pp_lo_ff[a][0]) + LS_W'(pp_lo_ff[a][1])
                  + LS_W'(pp_lo_ff[a][2]) + LS_W'(pp_lo_ff[a][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_SUM]) begin
         hs_ff <= hs_in;
         ls_ff <= ls_in;
      end
   end

   // final carry and scale
   logic [HS_W:0] tot_in [0:1];
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         tot_in[a] = {1'b0, hs_ff[a]} + (HS_W+1)'(ls_ff[a][LS_W-1:LIMB]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         res_ff[0] <= tot_in[0][LIMB +: COORD_BITS];
         res_ff[1] <= tot_in[1][LIMB +: COORD_BITS];
      end
   end

   assign rsp_tdata = OUT_W'({res_ff[1], res_ff[0]});

endmodule

/* hdl/cbs_checker.sv */
module cbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [cbs_pkg::OUT_W-1:0]     rsp_tdata,
   input logic                          csr_ready
);
   import cbs_pkg::*;

   logic [CNT_W-1:0] inflight_ff;
   logic             in_acc, out_acc;

   assign in_acc  = req_tvalid & req_tready;
   assign out_acc = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + CNT_W'(in_acc) - CNT_W'(out_acc);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("result without an accepted item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(NUM_STAGES))
      else $error("more items in flight than pipeline stages");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr write not taken");

endmodule

bind cubic_bezier_sampler_unit cbs_checker u_cbs_checker (.*);

/* sim/cubic_bezier_sampler_checker.sv */
module cubic_bezier_sampler_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [cbs_pkg::IN_W-1:0]      req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [cbs_pkg::OUT_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [cbs_pkg::STEP_BITS-1:0] csr_data,
   output int                            fail_count,
   output int                            pending
);

   import cbs_pkg::*;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   logic [STEP_BITS-1:0] seg_count;
   point_type            curve_fifo[$];

   // t in Q1.16 with the step clamped to the segment count
   function automatic logic [T_W-1:0] curve_param(input logic [STEP_BITS-1:0] step,
                                                  input logic [STEP_BITS-1:0] seg);
      logic [31:0] s;
      logic [31:0] j;
      s = (seg == '0) ? 32'd1 : 32'(seg);
      j = (32'(step) > s) ? s : 32'(step);
      return T_W'((j << FRAC_BITS) / s);
   endfunction

   // exact Bernstein blend of four coordinates, rounded half up
   function automatic coord_type blend_coord(input quad_type c, input logic [T_W-1:0] t);
      logic [79:0] tt;
      logic [79:0] uu;
      logic [79:0] acc;
      tt = 80'(t);
      uu = 80'(T_ONE) - tt;
      acc = uu * uu * uu * 80'(c[0])
          + 80'd3 * uu * uu * tt * 80'(c[1])
          + 80'd3 * uu * tt * tt * 80'(c[2])
          + tt * tt * tt * 80'(c[3]);
      acc = acc + (80'd1 << (W_SHIFT - 1));
      return acc[W_SHIFT +: COORD_BITS];
   endfunction

   function automatic point_type bezier_point(input logic [IN_W-1:0] d,
                                              input logic [STEP_BITS-1:0] seg);
      quad_type         xs;
      quad_type         ys;
      logic [T_W-1:0]   t;
      point_type        pt;
      for (int k = 0; k < 4; k++) begin
         xs[k] = d[2*k*COORD_BITS +: COORD_BITS];
         ys[k] = d[(2*k+1)*COORD_BITS +: COORD_BITS];
      end
      t = curve_param(d[8*COORD_BITS +: STEP_BITS], seg);
      pt.x = blend_coord(xs, t);
      pt.y = blend_coord(ys, t);
      return pt;
   endfunction

   always @(posedge clock) begin
      point_type want;
      point_type got;
      if (reset) begin
         seg_count = SEG_RESET;
         curve_fifo.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            seg_count = csr_data;
         end
         if (req_tvalid && req_tready) begin
            curve_fifo.insert(curve_fifo.size(), bezier_point(req_tdata, seg_count));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[OUT_BITS-1:0];
            if (curve_fifo.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected item: x %h y %h", got.x, got.y);
               end
            end else begin
               want = curve_fifo.pop_front();
               if (got.x !== want.x || got.y !== want.y) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected x %h y %h, got x %h y %h",
                              want.x, want.y, got.x, got.y);
                  end
               end
            end
         end
      end
      pending = curve_fifo.size();
   end

endmodule

/* sim/tb.sv */
module tb;

   import cbs_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = NUM_STAGES + 20;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [IN_W-1:0]      req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [OUT_W-1:0]     rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [STEP_BITS-1:0] csr_data;

   int                   fail_count;
   int                   pending;
   int                   cycle_count = 0;
   bit                   idle_on;
   logic [STEP_BITS-1:0] seg_now;

   cubic_bezier_sampler_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   cubic_bezier_sampler_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic quad_type quad(input coord_type c0, input coord_type c1,
                                     input coord_type c2, input coord_type c3);
      return {c3, c2, c1, c0};
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [STEP_BITS-1:0] rand_step(input logic [STEP_BITS-1:0] seg);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return seg;
         2: return STEP_BITS'($urandom_range(0, 1023));
         default: return STEP_BITS'($urandom_range(0, seg));
      endcase
   endfunction

   task automatic send_curve(input quad_type xs, input quad_type ys,
                             input logic [STEP_BITS-1:0] step);
      logic [IN_W-1:0] d;
      d = '0;
      for (int k = 0; k < 4; k++) begin
         d[2*k*COORD_BITS +: COORD_BITS]     = xs[k];
         d[(2*k+1)*COORD_BITS +: COORD_BITS] = ys[k];
      end
      d[8*COORD_BITS +: STEP_BITS] = step;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random();
      quad_type xs;
      quad_type ys;
      for (int k = 0; k < 4; k++) begin
         xs[k] = rand_coord();
         ys[k] = rand_coord();
      end
      send_curve(xs, ys, rand_step(seg_now));
   endtask

   // lower valid and wait for every item to come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_segments(input logic [STEP_BITS-1:0] seg);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= seg;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      seg_now = seg;
   endtask

   logic [STEP_BITS-1:0] seg_plan[8];

   initial begin
      idle_on     = 1'b1;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      seg_now     = SEG_RESET;
      seg_plan    = '{10'd1023, 10'd1, 10'd0, 10'd2, 10'd3, 10'd517, 10'd64, 10'd100};
      seg_plan[7] = STEP_BITS'($urandom_range(4, 1022));
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset segment count
      send_curve('0, '0, '0);
      send_curve('1, '1, '0);
      send_curve('1, '1, 10'd100);
      send_curve('1, '1, 10'd50);
      send_curve('1, '0, 10'd1023);
      send_curve('0, '1, 10'd101);
      send_curve(quad(16'h0000, 16'hffff, 16'hffff, 16'h0000),
                 quad(16'hffff, 16'h0000, 16'h0000, 16'hffff), 10'd50);
      send_curve(quad(16'h1234, 16'h5678, 16'h9abc, 16'hdef0),
                 quad(16'hfedc, 16'hba98, 16'h7654, 16'h3210), 10'd0);
      send_curve(quad(16'h1234, 16'h5678, 16'h9abc, 16'hdef0),
                 quad(16'hfedc, 16'hba98, 16'h7654, 16'h3210), 10'd100);
      send_curve(quad(16'haaaa, 16'h5555, 16'haaaa, 16'h5555),
                 quad(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 10'd33);
      send_curve(quad(16'h0000, 16'h0000, 16'h0000, 16'hffff),
                 quad(16'hffff, 16'h0000, 16'h0000, 16'h0000), 10'd1);
      send_curve(quad(16'h0000, 16'h0000, 16'h0000, 16'hffff),
                 quad(16'hffff, 16'h0000, 16'h0000, 16'h0000), 10'd99);
      send_curve(quad(16'h0001, 16'h0000, 16'h0000, 16'h0000),
                 quad(16'h0000, 16'h0000, 16'h0000, 16'h0001), 10'd50);
      send_curve(quad(16'h0000, 16'hffff, 16'h0000, 16'hffff),
                 quad(16'hffff, 16'hffff, 16'h0000, 16'h0000), 10'd512);
      for (int n = 0; n < 6; n++) begin
         send_random();
      end

      // random phases over several segment counts, the last without idling
      for (int p = 0; p < 8; p++) begin
         write_segments(seg_plan[p]);
         if (p == 7) begin
            idle_on = 1'b0;
         end
         if (p == 0) begin
            send_curve('1, '1, 10'd1023);
            send_curve('1, '0, 10'd1);
         end
         if (p == 2) begin
            send_curve(quad(16'h0000, 16'hffff, 16'hffff, 16'h8000),
                       quad(16'h8000, 16'h0000, 16'hffff, 16'hffff), 10'd0);
            send_curve(quad(16'h0000, 16'hffff, 16'hffff, 16'h8000),
                       quad(16'h8000, 16'h0000, 16'hffff, 16'hffff), 10'd1);
         end
         for (int n = 0; n < 100; n++) begin
            send_random();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
